### rtl/deadline_timer_queue_core_assert.svh
// assertion macros for the port checker file of the timer queue
// depends on nothing; included by the checker module
`ifndef DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define DTQ_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// implication whose right side is checked in the cycle after the left side holds
`define DTQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

### rtl/dtq_pkg.sv
// package of the deadline timer queue: widths, codes, queue beat type
// depends on nothing; imported by dtq_front, dtq_back, the top level and the bench
package dtq_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int ORDER_W    = 8;
   localparam int TIME_W     = 64;
   localparam int MAX_FIRE   = 16;
   localparam int FIRE_W     = $clog2(MAX_FIRE + 1);
   localparam logic [TIME_W-1:0] NO_DEADLINE = '1;

   // opcodes of an input beat
   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_DISARM = 2'd1,
      OP_TICK   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // classified command between front and back
   typedef struct packed {
      op_type            op;
      logic              slot_ok;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] value;
   } cmd_type;

   // back end state machine
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_EMIT
   } state_type;

endpackage

### rtl/dtq_front.sv
// front end: takes input beats, checks the slot range, pushes a command queue
// depends on dtq_pkg
module dtq_front
   import dtq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_op,
   input  logic [3:0]        in_slot,
   input  logic [TIME_W-1:0] in_deadline,
   input  logic [TIME_W-1:0] in_time,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output cmd_type           cmd
);

   localparam int DEPTH = 2;

   cmd_type         queue_ff [DEPTH];
   logic            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   cmd_type         new_cmd;
   logic            push;

   // classify the beat
   always_comb begin
      new_cmd.op      = op_type'(in_op);
      new_cmd.slot_ok = ({28'd0, in_slot} < SLOTS);
      new_cmd.slot    = in_slot[SLOT_W-1:0];
      new_cmd.value   = (op_type'(in_op) == OP_TICK) ? in_time : in_deadline;
   end

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign push      = in_valid && in_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/dtq_back.sv
// back end: slot table, serial minimum search, firing and result register
// depends on dtq_pkg
module dtq_back
   import dtq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  cmd_type           cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_accepted,
   output logic              out_fired,
   output logic [3:0]        out_slot,
   output logic [TIME_W-1:0] out_earliest,
   output logic              out_last
);

   logic [TIME_W-1:0]  dl_ff [SLOTS];
   logic [ORDER_W-1:0] ord_ff [SLOTS];
   logic [SLOTS-1:0]   pend_ff, pend_in;
   logic [ORDER_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]  cache_ff, cache_in;
   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [SLOT_W:0]    idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  best_ff, best_in;
   logic [FIRE_W-1:0]  nfire_ff, nfire_in;
   logic               ov_ff, ov_in;
   logic               oacc_ff, oacc_in, ofire_ff, ofire_in, olast_ff, olast_in;
   logic [3:0]         oslot_ff, oslot_in;
   logic               hold_ff, hold_in;
   logic [3:0]         hslot_ff, hslot_in;
   logic               wr_arm;
   logic               do_shift;
   logic [SLOT_W-1:0]  rm_slot;
   logic [SLOT_W-1:0]  iw;
   logic               better;

   assign iw = idx_ff[SLOT_W-1:0];
   assign better = pend_ff[iw] && (!found_ff
                   || dl_ff[iw] < dl_ff[best_ff]
                   || (dl_ff[iw] == dl_ff[best_ff] && ord_ff[iw] < ord_ff[best_ff]));

   assign out_valid    = ov_ff;
   assign out_accepted = oacc_ff;
   assign out_fired    = ofire_ff;
   assign out_slot     = oslot_ff;
   assign out_earliest = cache_ff;
   assign out_last     = olast_ff;

   // next state and outputs
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      best_in  = best_ff;
      nfire_in = nfire_ff;
      pend_in  = pend_ff;
      cnt_in   = cnt_ff;
      cache_in = cache_ff;
      ov_in    = ov_ff && !out_ready;
      oacc_in  = oacc_ff;
      ofire_in = ofire_ff;
      oslot_in = oslot_ff;
      olast_in = olast_ff;
      hold_in  = hold_ff;
      hslot_in = hslot_ff;
      cmd_pop  = 1'b0;
      wr_arm   = 1'b0;
      do_shift = 1'b0;
      rm_slot  = cur_ff.slot;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !ov_in) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               ov_in    = 1'b1;
               oacc_in  = 1'b0;
               ofire_in = 1'b0;
               oslot_in = 4'd0;
               olast_in = 1'b1;
               case (cmd.op)
                  OP_ARM: begin
                     if (cmd.slot_ok && !pend_ff[cmd.slot]) begin
                        wr_arm   = 1'b1;
                        pend_in[cmd.slot] = 1'b1;
                        cnt_in   = cnt_ff + 1'b1;
                        oacc_in  = 1'b1;
                        if (cmd.value < cache_ff) cache_in = cmd.value;
                     end
                  end
                  OP_DISARM: begin
                     if (cmd.slot_ok && pend_ff[cmd.slot]) begin
                        do_shift = 1'b1;
                        rm_slot  = cmd.slot;
                        pend_in[cmd.slot] = 1'b0;
                        if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                        oacc_in  = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (cmd.value >= cache_ff) begin
                        ov_in    = 1'b0;
                        cache_in = NO_DEADLINE;
                        nfire_in = '0;
                        hold_in  = 1'b0;
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = ST_SEARCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (better) begin
               found_in = 1'b1;
               best_in  = iw;
            end
            // first pass: earliest deadline that stays after firing, known before any beat
            if (nfire_ff == '0 && pend_ff[iw] && dl_ff[iw] > cur_ff.value
                && dl_ff[iw] < cache_ff) begin
               cache_in = dl_ff[iw];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (SLOT_W+1)'(SLOTS - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (found_ff && cur_ff.value >= dl_ff[best_ff]
                && nfire_ff != FIRE_W'(MAX_FIRE)) begin
               state_in = ST_SHIFT;
            end else begin
               if (found_ff) cache_in = dl_ff[best_ff];
               state_in = ST_EMIT;
            end
         end
         ST_SHIFT: begin
            // emit any previous fired beat in the same cycle as removing the next one
            if (!ov_in) begin
               if (hold_ff) begin
                  ov_in    = 1'b1;
                  oacc_in  = 1'b0;
                  ofire_in = 1'b1;
                  oslot_in = hslot_ff;
                  olast_in = 1'b0;
               end
               do_shift = 1'b1;
               rm_slot  = best_ff;
               pend_in[best_ff] = 1'b0;
               if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
               hold_in  = 1'b1;
               hslot_in = 4'(best_ff);
               nfire_in = nfire_ff + 1'b1;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_EMIT: begin
            if (!ov_in) begin
               ov_in    = 1'b1;
               oacc_in  = 1'b0;
               ofire_in = hold_ff;
               oslot_in = hold_ff ? hslot_ff : 4'd0;
               olast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
         cnt_ff   <= '0;
         cache_ff <= NO_DEADLINE;
         ov_ff    <= 1'b0;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         cache_ff <= cache_in;
         ov_ff    <= ov_in;
         hold_ff  <= hold_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      nfire_ff <= nfire_in;
      oacc_ff  <= oacc_in;
      ofire_ff <= ofire_in;
      oslot_ff <= oslot_in;
      olast_ff <= olast_in;
      hslot_ff <= hslot_in;
   end

   // slot table: arm writes, removal closes the order gap
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (wr_arm && cmd.slot == SLOT_W'(i)) begin
            dl_ff[i]  <= cmd.value;
            ord_ff[i] <= cnt_ff;
         end else if (do_shift && pend_ff[i] && SLOT_W'(i) != rm_slot
                      && ord_ff[i] > ord_ff[rm_slot]) begin
            ord_ff[i] <= ord_ff[i] - 1'b1;
         end
      end
   end

endmodule

### rtl/deadline_timer_queue_core.sv
// channel   | dir | beat contents
// req       | in  | tdata: operation, slot, deadline, current_time
// rsp       | out | tdata: accepted, fired, fired_slot, earliest_deadline; tlast
// arm, disarm, nop and a tick that is not due: result registered after the req beat
// passes the command queue, one beat per cycle while rsp is ready.
// a due tick runs the serial minimum search over the slots before the first fire
// and again after each one, then emits its last beat.
// reset clears pending flags, the queue and the cached deadline at once.
// the two-entry command queue keeps req open for up to two beats while rsp stalls.
module deadline_timer_queue_core
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], slot[5:2], deadline[69:6], current_time[133:70], zero fill
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted[0], fired[1], fired_slot[5:2], earliest_deadline[69:6], zero fill
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic              cmd_valid, cmd_pop;
   cmd_type           cmd;
   logic              acc, fir;
   logic [3:0]        fslot;
   logic [TIME_W-1:0] earliest;

   dtq_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tdata[1:0]), .in_slot(req_tdata[5:2]),
      .in_deadline(req_tdata[69:6]), .in_time(req_tdata[133:70]),
      .cmd_valid, .cmd_pop, .cmd
   );

   dtq_back u_back (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_accepted(acc), .out_fired(fir), .out_slot(fslot),
      .out_earliest(earliest), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, earliest, fslot, fir, acc};

endmodule

### rtl/dtq_checker.sv
// port checker of the timer queue, bound to the top level
// depends on deadline_timer_queue_core_assert.svh
`include "deadline_timer_queue_core_assert.svh"
module dtq_port_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // a stalled result beat holds
   `DTQ_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // accepted and fired never together
   `DTQ_ASSERT_IMP(acc_fire_excl, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]))
   // an accepted beat is always the last of its input
   `DTQ_ASSERT_IMP(acc_last, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tlast)
   // a non-last beat reports a fired slot
   `DTQ_ASSERT_IMP(mid_fired, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[1])

endmodule

bind deadline_timer_queue_core dtq_port_checker u_dtq_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);

### tb/sv/dtq_checker.sv
// checker of the deadline timer queue: tracks slot state from accepted req beats,
// predicts rsp beats and compares them field by field; depends on dtq_pkg
`timescale 1ns / 100ps

module dtq_checker
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending_rsp,
   output int           fired_total
);

   typedef struct packed {
      logic              accepted;
      logic              fired;
      logic [3:0]        fired_slot;
      logic [TIME_W-1:0] earliest;
      logic              last;
   } rsp_beat_type;

   // shadow of the timer table
   logic [TIME_W-1:0] tbl_deadline [SLOTS];
   logic              tbl_pending  [SLOTS];
   logic [7:0]        tbl_rank     [SLOTS];
   logic [7:0]        armed_count;
   logic [TIME_W-1:0] earliest_cache;
   rsp_beat_type      expected_rsp [$];

   assign pending_rsp = expected_rsp.size();

   // first pending slot in firing order, SLOTS when none
   function automatic int next_due();
      int best;
      best = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_pending[i] && (best == SLOTS || tbl_deadline[i] < tbl_deadline[best] ||
             (tbl_deadline[i] == tbl_deadline[best] && tbl_rank[i] < tbl_rank[best])))
            best = i;
      end
      return best;
   endfunction

   task automatic drop_slot(input int s);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_pending[i] && i != s && tbl_rank[i] > tbl_rank[s])
            tbl_rank[i] = tbl_rank[i] - 8'd1;
      tbl_pending[s] = 1'b0;
      if (armed_count > 0) armed_count = armed_count - 8'd1;
   endtask

   // works out every rsp beat caused by one req beat
   task automatic predict_beat(input logic [135:0] beat);
      op_type            op;
      int                s;
      int                f;
      logic [TIME_W-1:0] dl;
      logic [TIME_W-1:0] now;
      rsp_beat_type      outs [$];
      rsp_beat_type      r;
      logic              ok;
      op  = op_type'(beat[1:0]);
      s   = int'(beat[5:2]);
      dl  = beat[69:6];
      now = beat[133:70];
      r   = '0;
      ok  = 1'b0;
      if (op == OP_ARM || op == OP_DISARM) begin
         if (op == OP_ARM && !tbl_pending[s]) begin
            tbl_pending[s]  = 1'b1;
            tbl_deadline[s] = dl;
            tbl_rank[s]     = armed_count;
            armed_count     = armed_count + 8'd1;
            if (dl < earliest_cache) earliest_cache = dl;
            ok = 1'b1;
         end else if (op == OP_DISARM && tbl_pending[s]) begin
            drop_slot(s);
            ok = 1'b1;
         end
         r.accepted = ok;
         r.last = 1'b1;
         outs.push_back(r);
      end else if (op == OP_TICK && now >= earliest_cache) begin
         earliest_cache = NO_DEADLINE;
         forever begin
            f = next_due();
            if (f >= SLOTS) break;
            if (now < tbl_deadline[f] || outs.size() >= MAX_FIRE) begin
               earliest_cache = tbl_deadline[f];
               break;
            end
            drop_slot(f);
            r = '0;
            r.fired = 1'b1;
            r.fired_slot = 4'(f);
            outs.push_back(r);
         end
         if (outs.size() == 0) begin
            r = '0;
            r.last = 1'b1;
            outs.push_back(r);
         end else
            outs[outs.size()-1].last = 1'b1;
      end else begin
         r.last = 1'b1;
         outs.push_back(r);
      end
      foreach (outs[k]) begin
         outs[k].earliest = earliest_cache;
         expected_rsp.push_back(outs[k]);
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_beat_type e;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) tbl_pending[i] = 1'b0;
         armed_count    = '0;
         earliest_cache = NO_DEADLINE;
         expected_rsp.delete();
         fail_count  = 0;
         fired_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_tdata);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (e.fired) fired_total++;
               if (rsp_tdata[0] !== e.accepted) begin
                  $error("accepted: expected %0d, got %0d", e.accepted, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== e.fired) begin
                  $error("fired: expected %0d, got %0d", e.fired, rsp_tdata[1]);
                  fail_count++;
               end
               if (rsp_tdata[5:2] !== e.fired_slot) begin
                  $error("fired_slot: expected %0d, got %0d", e.fired_slot, rsp_tdata[5:2]);
                  fail_count++;
               end
               if (rsp_tdata[69:6] !== e.earliest) begin
                  $error("earliest_deadline: expected %h, got %h", e.earliest,
                         rsp_tdata[69:6]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_beat(req_tdata);
      end
   end

endmodule

### tb/sv/tb_deadline_timer_queue_core.sv
// top of the timer queue bench: clock, reset, req stimulus, rsp stalls, verdict
// depends on dtq_pkg, deadline_timer_queue_core and dtq_checker
`timescale 1ns / 100ps

module tb_deadline_timer_queue_core
   import dtq_pkg::*;
();

   localparam int WATCHDOG = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         rsp_tlast;
   int           fail_count;
   int           pending_rsp;
   int           fired_total;
   int           idle_cycles = 0;
   int           beats_sent = 0;
   bit           calm = 1'b0;
   bit           hold_rsp = 1'b0;
   bit           timed_out = 1'b0;
   logic [TIME_W-1:0] sim_now = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   deadline_timer_queue_core uut (.*);

   dtq_checker chk (.*);

   // drive one req beat and wait for its handshake
   task automatic send_beat(input op_type op, input logic [3:0] s,
                            input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] now);
      if (!calm && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tdata  <= {2'b00, now, dl, s, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_rsp != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // random deadline close to the running clock so ticks fire often
   function automatic logic [TIME_W-1:0] near_deadline();
      return sim_now + $urandom_range(0, 200);
   endfunction

   // receiver: random stall bursts, or a long hold-off when asked
   initial begin
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         timed_out = 1'b1;
      end
   end

   initial begin
      wait (timed_out);
      $display("watchdog expired with %0d rsp beats outstanding", pending_rsp);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int op_sel;
      logic [3:0] s;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: refusals, extremes, ties, stale cache, a full table fired by one tick
      send_beat(OP_DISARM, 4'd0, '0, '0);
      send_beat(OP_TICK, 4'd0, '0, '0);
      send_beat(OP_TICK, 4'd0, '0, NO_DEADLINE);
      send_beat(OP_NOP, 4'hF, NO_DEADLINE, NO_DEADLINE);
      send_beat(OP_ARM, 4'd15, NO_DEADLINE, '0);
      send_beat(OP_ARM, 4'd15, 64'd5, '0);
      send_beat(OP_ARM, 4'd0, '0, NO_DEADLINE);
      send_beat(OP_ARM, 4'd3, 64'd100, '0);
      send_beat(OP_ARM, 4'd2, 64'd100, '0);
      send_beat(OP_TICK, 4'd0, '0, 64'd99);
      send_beat(OP_DISARM, 4'd0, '0, '0);
      send_beat(OP_TICK, 4'd0, '0, 64'd50);
      send_beat(OP_TICK, 4'd0, '0, 64'd100);
      send_beat(OP_TICK, 4'd0, '0, NO_DEADLINE);
      for (int i = 0; i < 16; i++)
         send_beat(OP_ARM, i[3:0], 64'd7 - (i % 3), '0);
      send_beat(OP_DISARM, 4'd9, '0, '0);
      send_beat(OP_ARM, 4'd9, 64'h5555_AAAA_5555_AAAA, '0);
      send_beat(OP_TICK, 4'd0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
      send_beat(OP_TICK, 4'd0, '0, NO_DEADLINE);

      // hold off the receiver while req keeps coming
      hold_rsp = 1'b1;
      for (int i = 0; i < 16; i++)
         send_beat(OP_ARM, i[3:0], 64'd10 + i, '0);
      send_beat(OP_TICK, 4'd0, '0, 64'd1000);
      drain_all();

      // random: arms, disarms and advancing ticks, some nop noise
      for (int n = 0; n < 110; n++) begin
         if (n == 90) calm = 1'b1;
         op_sel = $urandom_range(0, 9);
         s = 4'($urandom_range(0, 15));
         if (op_sel < 4)
            send_beat(OP_ARM, s, ($urandom_range(9) == 0) ?
                      {$urandom, $urandom} : near_deadline(), {$urandom, $urandom});
         else if (op_sel < 6)
            send_beat(OP_DISARM, s, {$urandom, $urandom}, {$urandom, $urandom});
         else if (op_sel < 9) begin
            sim_now = sim_now + $urandom_range(0, 120);
            send_beat(OP_TICK, s, {$urandom, $urandom}, sim_now);
         end else
            send_beat(OP_NOP, s, {$urandom, $urandom}, {$urandom, $urandom});
      end
      send_beat(OP_TICK, 4'd0, '0, NO_DEADLINE);
      drain_all();

      $display("sent %0d req beats; %0d slots fired across arm, disarm, tick and nop",
               beats_sent, fired_total);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_front.sv
rtl/dtq_back.sv
rtl/deadline_timer_queue_core.sv
rtl/dtq_checker.sv
tb/sv/dtq_checker.sv
tb/sv/tb_deadline_timer_queue_core.sv
